// File: rtl/core/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg : literal substring search shared definitions
// Widths, register indexes and payload types for the substring search block.
// ----------------------------------------------------------------------------
package lss_pkg;

   localparam int PATTERN_MAX    = 32;
   localparam int OFFSET_WIDTH   = 28;
   localparam int WINDOW_DEPTH   = PATTERN_MAX - 1;
   localparam int WORD_WIDTH     = 64;
   localparam int WORD_BYTES     = WORD_WIDTH / 8;
   localparam int PATTERN_WORDS  = PATTERN_MAX / WORD_BYTES;
   localparam int LEN_WIDTH      = $clog2(PATTERN_MAX + 1);
   localparam int PAT_IDX_WIDTH  = $clog2(PATTERN_MAX);
   localparam int CSR_IDX_WIDTH  = 3;

   typedef logic [7:0]                byte_type;
   typedef logic [OFFSET_WIDTH-1:0]   offset_type;
   typedef logic [WORD_WIDTH-1:0]     word_type;
   typedef logic [LEN_WIDTH-1:0]      len_type;
   typedef logic [CSR_IDX_WIDTH-1:0]  csr_index_type;

   localparam csr_index_type CSR_PATTERN_WORD_0 = 3'd0;
   localparam csr_index_type CSR_PATTERN_WORD_1 = 3'd1;
   localparam csr_index_type CSR_PATTERN_WORD_2 = 3'd2;
   localparam csr_index_type CSR_PATTERN_WORD_3 = 3'd3;
   localparam csr_index_type CSR_PATTERN_LENGTH = 3'd4;

   localparam offset_type OFFSET_MAX = {OFFSET_WIDTH{1'b1}};

endpackage

// File: rtl/core/literal_substring_search.sv
// ----------------------------------------------------------------------------
// literal_substring_search : streaming search for a configured literal
// Compares the newest byte and a window of earlier bytes with the pattern
// every beat and reports the first match offset or a miss at stream end.
// ----------------------------------------------------------------------------
// an accepted byte's result is registered in the output register in the next cycle
// throughput: one byte per cycle, set by the combinational parallel window compare
// a new byte is taken while the result register is empty or being drained
// reset (synchronous): pattern registers, length, byte count, match flag and
// result valid clear; the window is not cleared, it is refilled by each stream
// ----------------------------------------------------------------------------
module literal_substring_search (
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  lss_pkg::csr_index_type csr_index,
   input  lss_pkg::word_type      csr_data,
   // stream bytes
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lss_pkg::byte_type      req_data_byte,
   input  logic                   req_end_of_stream,
   // results
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_found,
   output lss_pkg::offset_type    rsp_match_offset,
   output logic                   rsp_stream_done
);
   import lss_pkg::*;

   word_type   pattern_word_ff [PATTERN_WORDS];
   len_type    pattern_length_ff;

   byte_type   window_ff [WINDOW_DEPTH];
   offset_type bytes_seen_ff;
   logic       matched_ff;
   logic       matched_in;
   offset_type bytes_seen_in;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       rsp_found_ff;
   logic       rsp_found_in;
   offset_type rsp_offset_ff;
   offset_type rsp_offset_in;
   logic       rsp_done_ff;
   logic       rsp_done_in;

   byte_type   pattern_bytes [PATTERN_MAX];
   byte_type   aligned [PATTERN_MAX];
   byte_type   hist [PATTERN_MAX];
   len_type    len_eff;
   len_type    len_m1;
   logic       enough;
   logic       all_eq;
   logic       hit;
   logic       accept;
   offset_type offset;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // pattern aligned to the history, newest byte against the last pattern byte
   always_comb begin
      len_type idx;
      idx = '0;
      for (int w = 0; w < PATTERN_WORDS; w++) begin
         for (int b = 0; b < WORD_BYTES; b++) begin
            pattern_bytes[w*WORD_BYTES + b] = pattern_word_ff[w][8*b +: 8];
         end
      end
      len_eff = (pattern_length_ff > len_type'(PATTERN_MAX)) ?
                len_type'(PATTERN_MAX) : pattern_length_ff;
      len_m1  = len_eff - len_type'(1);
      hist[0] = req_data_byte;
      for (int i = 1; i < PATTERN_MAX; i++) begin
         hist[i] = window_ff[i-1];
      end
      all_eq = 1'b1;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         idx        = len_m1 - len_type'(i);
         aligned[i] = pattern_bytes[idx[PAT_IDX_WIDTH-1:0]];
         if (len_type'(i) < len_eff && hist[i] != aligned[i]) begin
            all_eq = 1'b0;
         end
      end
   end

   always_comb begin
      enough = bytes_seen_ff >= OFFSET_WIDTH'(len_m1);
      priority if (matched_ff) begin
         hit = 1'b0;
      end else if (len_eff == '0) begin
         hit = 1'b1;
      end else begin
         hit = enough & all_eq;
      end
      priority if (len_eff == '0) begin
         offset = '0;
      end else if (bytes_seen_ff == OFFSET_MAX) begin
         offset = OFFSET_MAX;
      end else begin
         offset = bytes_seen_ff - OFFSET_WIDTH'(len_m1);
      end
   end

   always_comb begin
      matched_in    = matched_ff;
      bytes_seen_in = bytes_seen_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_found_in  = rsp_found_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_done_in   = rsp_done_ff;
      if (accept) begin
         rsp_valid_in  = hit | (~matched_ff & req_end_of_stream);
         rsp_found_in  = hit;
         rsp_offset_in = hit ? offset : '0;
         rsp_done_in   = req_end_of_stream;
         if (req_end_of_stream) begin
            matched_in    = 1'b0;
            bytes_seen_in = '0;
         end else begin
            matched_in    = matched_ff | hit;
            bytes_seen_in = (bytes_seen_ff == OFFSET_MAX) ?
                            bytes_seen_ff : bytes_seen_ff + offset_type'(1);
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < PATTERN_WORDS; w++) begin
            pattern_word_ff[w] <= '0;
         end
         pattern_length_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PATTERN_WORD_0: pattern_word_ff[0] <= csr_data;
            CSR_PATTERN_WORD_1: pattern_word_ff[1] <= csr_data;
            CSR_PATTERN_WORD_2: pattern_word_ff[2] <= csr_data;
            CSR_PATTERN_WORD_3: pattern_word_ff[3] <= csr_data;
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_data[LEN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // window entries are only compared once this stream has filled them
   always_ff @(posedge clock) begin
      if (accept && !req_end_of_stream) begin
         window_ff[0] <= req_data_byte;
         for (int i = 1; i < WINDOW_DEPTH; i++) begin
            window_ff[i] <= window_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matched_ff    <= 1'b0;
         bytes_seen_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         matched_ff    <= matched_in;
         bytes_seen_ff <= bytes_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff  <= rsp_found_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_match_offset = rsp_offset_ff;
   assign rsp_stream_done  = rsp_done_ff;

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb : literal substring search testbench
// Loads patterns through the register port and streams bytes at the search
// block. A predictor kept in step with every accepted beat forecasts each
// result. A directed part covers the empty pattern, extreme byte values, too
// few bytes, a clamped length and the quiet period after a match. Random
// streams follow, most of them carrying the pattern whole, damaged or cut off,
// under several idle and stall mixes on both channels.
// ----------------------------------------------------------------------------
module tb;
   import lss_pkg::*;

   localparam int CYCLE_LIMIT  = 400_000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 1250;
   localparam int MAX_GAP      = 20;

   typedef logic [8*PATTERN_MAX-1:0] pattern_bits_type;

   typedef struct packed {
      logic       found;
      offset_type offset;
      logic       done;
   } search_result_type;

   logic          clock             = 1'b0;
   logic          reset             = 1'b1;
   logic          csr_valid         = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index         = CSR_PATTERN_WORD_0;
   word_type      csr_data          = '0;
   logic          req_valid         = 1'b0;
   logic          req_stall;
   byte_type      req_data_byte     = '0;
   logic          req_end_of_stream = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall         = 1'b0;
   logic          rsp_found;
   offset_type    rsp_match_offset;
   logic          rsp_stream_done;

   int sender_idle_pct = 0;
   int stall_pct       = 0;
   int error_count     = 0;
   int cycle_count     = 0;
   int searched_bytes  = 0;

   // predictor state
   pattern_bits_type  pattern_bits = '0;
   len_type           pattern_len  = '0;
   byte_type          recent_bytes [WINDOW_DEPTH];
   offset_type        stream_count;
   logic              match_seen;
   search_result_type expected_results [$];

   literal_substring_search u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_match_offset  (rsp_match_offset),
      .rsp_stream_done   (rsp_stream_done)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin : check_results
      search_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result: found %0d match_offset %0d stream_done %0d",
                   rsp_found, rsp_match_offset, rsp_stream_done);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_found !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_found);
               error_count++;
            end
            if (rsp_match_offset !== want.offset) begin
               $error("match_offset: expected %0d, actual %0d",
                      want.offset, rsp_match_offset);
               error_count++;
            end
            if (rsp_stream_done !== want.done) begin
               $error("stream_done: expected %0d, actual %0d",
                      want.done, rsp_stream_done);
               error_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic byte_type pattern_byte(input int idx);
      if (idx >= PATTERN_MAX) return '0;
      return pattern_bits[8*idx +: 8];
   endfunction

   function automatic int active_length();
      return (pattern_len > PATTERN_MAX) ? PATTERN_MAX : int'(pattern_len);
   endfunction

   task automatic clear_stream_state();
      for (int i = 0; i < WINDOW_DEPTH; i++) recent_bytes[i] = '0;
      stream_count = '0;
      match_seen   = 1'b0;
   endtask

   // window compare on one accepted byte, newest window entry is index 0
   task automatic predict_search(input byte_type data, input logic last);
      int         len;
      int         pos;
      logic       hit;
      offset_type start;
      len   = active_length();
      hit   = 1'b0;
      start = '0;
      searched_bytes++;
      if (!match_seen) begin
         if (len == 0) begin
            hit = 1'b1;
         end else if (int'(stream_count) >= len - 1) begin
            hit = (pattern_byte(len - 1) == data);
            for (int k = 0; k + 1 < len; k++) begin
               pos = len - 2 - k;
               if (pos >= WINDOW_DEPTH || recent_bytes[pos] != pattern_byte(k)) hit = 1'b0;
            end
            if (hit) begin
               start = (stream_count == OFFSET_MAX) ? OFFSET_MAX
                                                    : stream_count - offset_type'(len - 1);
            end
         end
         if (hit) begin
            match_seen = 1'b1;
            expected_results.push_back('{found: 1'b1, offset: start, done: last});
         end else if (last) begin
            expected_results.push_back('{found: 1'b0, offset: '0, done: 1'b1});
         end
      end
      if (last) begin
         clear_stream_state();
      end else begin
         for (int i = WINDOW_DEPTH - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
         recent_bytes[0] = data;
         if (stream_count != OFFSET_MAX) stream_count++;
      end
   endtask

   // leaves csr_valid high so back-to-back writes never drop it
   task automatic csr_write(input csr_index_type index, input word_type data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_PATTERN_WORD_0: pattern_bits[0*WORD_WIDTH +: WORD_WIDTH] = data;
         CSR_PATTERN_WORD_1: pattern_bits[1*WORD_WIDTH +: WORD_WIDTH] = data;
         CSR_PATTERN_WORD_2: pattern_bits[2*WORD_WIDTH +: WORD_WIDTH] = data;
         CSR_PATTERN_WORD_3: pattern_bits[3*WORD_WIDTH +: WORD_WIDTH] = data;
         CSR_PATTERN_LENGTH: pattern_len = data[LEN_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic load_pattern(input pattern_bits_type bits, input int len);
      csr_write(CSR_PATTERN_WORD_0, bits[0*WORD_WIDTH +: WORD_WIDTH]);
      csr_write(CSR_PATTERN_WORD_1, bits[1*WORD_WIDTH +: WORD_WIDTH]);
      csr_write(CSR_PATTERN_WORD_2, bits[2*WORD_WIDTH +: WORD_WIDTH]);
      csr_write(CSR_PATTERN_WORD_3, bits[3*WORD_WIDTH +: WORD_WIDTH]);
      csr_write(CSR_PATTERN_LENGTH, word_type'(len));
      csr_valid <= 1'b0;
   endtask

   // valid stays high between beats unless an idle gap is taken
   task automatic send_byte(input byte_type data, input logic last);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= data;
      req_end_of_stream <= last;
      do @(posedge clock); while (req_stall);
      predict_search(data, last);
   endtask

   // bytes listed left to right in the literal, last one closes the stream
   task automatic send_sequence(input logic [8*16-1:0] seq, input int count);
      for (int i = 0; i < count; i++) send_byte(seq[8*(count-1-i) +: 8], i == count - 1);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic pattern_bits_type random_pattern();
      pattern_bits_type bits;
      logic             narrow;
      narrow = $urandom_range(1);
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (narrow) begin
            // few symbols give repeats and overlapping partial matches
            case ($urandom_range(3))
               0:       bits[8*i +: 8] = 8'h00;
               1:       bits[8*i +: 8] = 8'hff;
               2:       bits[8*i +: 8] = "a";
               default: bits[8*i +: 8] = "b";
            endcase
         end else begin
            bits[8*i +: 8] = byte_type'($urandom_range(255));
         end
      end
      return bits;
   endfunction

   function automatic int random_length();
      int r;
      r = $urandom_range(99);
      if (r < 5)  return 0;
      if (r < 15) return PATTERN_MAX;
      if (r < 22) return $urandom_range(PATTERN_MAX + 1, 2**LEN_WIDTH - 1);
      if (r < 35) return $urandom_range(9, PATTERN_MAX - 1);
      return $urandom_range(1, 8);
   endfunction

   function automatic byte_type filler_byte(input int len);
      if (len > 0 && $urandom_range(3) != 0) return pattern_byte($urandom_range(len - 1));
      return byte_type'($urandom_range(255));
   endfunction

   task automatic send_random_stream();
      byte_type stream_q [$];
      int       len;
      int       lead;
      int       tail;
      int       flip_at;
      len  = active_length();
      lead = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(12);
      tail = $urandom_range(12);
      for (int i = 0; i < lead; i++) stream_q.push_back(filler_byte(len));
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: begin
            for (int k = 0; k < len; k++) stream_q.push_back(pattern_byte(k));
         end
         6, 7: begin
            flip_at = $urandom_range(len > 0 ? len - 1 : 0);
            for (int k = 0; k < len; k++) begin
               stream_q.push_back(pattern_byte(k) ^
                                  (k == flip_at ? byte_type'($urandom_range(1, 255)) : 8'h00));
            end
         end
         8: begin
            // stream ends one byte short of a match
            for (int k = 0; k < len - 1; k++) stream_q.push_back(pattern_byte(k));
            tail = 0;
         end
         default: ;
      endcase
      for (int i = 0; i < tail; i++) stream_q.push_back(filler_byte(len));
      if (stream_q.size() == 0) stream_q.push_back(byte_type'($urandom_range(255)));
      foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
   endtask

   task automatic test_empty_pattern();
      load_pattern(random_pattern(), 0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b0);
      send_byte(8'h5a, 1'b1);
      wait_idle();
   endtask

   task automatic test_extreme_bytes();
      pattern_bits_type bits;
      bits         = random_pattern();
      bits[23:0]   = 24'hff00ff;
      load_pattern(bits, 3);
      send_sequence(128'h00ff0000ff00ff, 7);
      wait_idle();
   endtask

   task automatic test_too_few_bytes();
      pattern_bits_type bits;
      bits       = random_pattern();
      bits[31:0] = '0;
      // zeroed window must not stand in for bytes not yet seen
      load_pattern(bits, 4);
      send_sequence(128'h000000, 3);
      send_sequence(128'h00000000, 4);
      wait_idle();
   endtask

   task automatic test_long_length();
      load_pattern(random_pattern(), 2**LEN_WIDTH - 1);
      send_sequence(128'h1234, 2);
      wait_idle();
   endtask

   task automatic test_after_match();
      pattern_bits_type bits;
      bits      = random_pattern();
      bits[7:0] = "a";
      load_pattern(bits, 1);
      send_sequence("aab", 3);
      send_sequence("ba", 2);
      wait_idle();
   endtask

   task automatic test_random_streams(input int idle_chance, input int stall_chance,
                                      input int target);
      int first_count;
      sender_idle_pct = idle_chance;
      stall_pct       = stall_chance;
      first_count     = searched_bytes;
      while (searched_bytes - first_count < target) begin
         load_pattern(random_pattern(), random_length());
         repeat ($urandom_range(2, 6)) send_random_stream();
         wait_idle();
      end
   endtask

   initial begin
      clear_stream_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_pattern();
      test_extreme_bytes();
      test_too_few_bytes();
      test_long_length();
      test_after_match();
      test_random_streams(0, 0, RANDOM_ITEMS / 4);
      test_random_streams(68, 0, RANDOM_ITEMS / 4);
      test_random_streams(0, 68, RANDOM_ITEMS / 4);
      test_random_streams(30, 30, RANDOM_ITEMS / 4);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
